FILE: sv/ipg_pkg.sv
// ipg_pkg: shared types and constants for the integer partition generator
// request and response word layouts, op codes, sequencer states
// no dependencies
package ipg_pkg;

  localparam int MAX_N_DEF = 32;
  localparam int N_W       = 6;
  localparam int VAL_W     = 6;
  localparam int POS_W     = 5;
  localparam int NUM_W     = 14;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic           op;
    logic [N_W-1:0] n;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] part_value;
    logic [POS_W-1:0] part_position;
    logic             last_part;
    logic             final_partition;
    logic             exhausted;
    logic [NUM_W-1:0] partition_number;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_EMIT,
    ST_EXH
  } state_t;

endpackage

FILE: sv/ipg_parts_ram.sv
// ipg_parts_ram: parts store, one write and one registered read per cycle
// a write and a read of the same entry in one cycle return the new data
// depends on nothing
module ipg_parts_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-to-read forwarding
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/integer_partition_generator.sv
// integer_partition_generator: steps through the partitions of n, largest parts first
// depends on ipg_pkg and ipg_parts_ram
// req (valid/ready): op = start loads n (0 taken as 1, above MAX_N clamped) and yields
//   the partition [n]; op = next advances to the following partition
// rsp (valid/ready): one word per part, largest first; last_part on the final word of a
//   run, final_partition on every word of the all-ones partition; a next after the
//   final partition or before any start gives one exhausted word with part_value 0
// timing: req_ready is high only while the sequencer is idle, one request at a time
//   start: accept cycle, then the single word of [n]
//   next: accept cycle, a read of the head part, for a split a write of each copy of the
//   reduced part and a closing step for the remainder, then one word per part
//   the parts store has a single write port, and the emit walk sends one part per
//   cycle while the response register is free
//   the response word sits in an output register, so the next request is taken
//   while the last word of a run still waits for rsp_ready
// reset: rst clears control state and the generation flag; the parts store needs no
//   clearing pass, entries past the head index are emitted as one whatever they hold
// stall: while rsp_ready is low the run simply pauses; nothing is dropped or repeated
module integer_partition_generator #(
  parameter int MAX_N = ipg_pkg::MAX_N_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ipg_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ipg_pkg::rsp_t rsp
);

  import ipg_pkg::*;

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;  // part index
  localparam int HW = $clog2(MAX_N + 1);                // head index plus one
  localparam int TW = N_W + 1;                          // remainder in split loop
  localparam int SW = N_W + 1;                          // running sum of a run

  // sequencer state
  state_t state, state_next;

  // generation state: hp1 is head index plus one, so zero means no part above one
  logic [HW-1:0]    hp1, hp1_next;
  logic [IW-1:0]    tail, tail_next;
  logic [N_W-1:0]   target, target_next;
  logic [NUM_W-1:0] counter, counter_next;
  logic             active, active_next;
  logic             p0_one, p0_one_next;   // first part equals one

  // split loop working registers
  logic [VAL_W-1:0] r, r_next;
  logic [TW-1:0]    t, t_next;

  // emit walk
  logic [IW-1:0]    idx, idx_next;
  logic [SW-1:0]    sum, sum_next;

  // response register
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  // parts store port
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // helpers
  logic [N_W-1:0]   n_eff;
  logic [IW-1:0]    head;
  logic [VAL_W-1:0] part;
  logic [SW-1:0]    sum_new;
  logic             run_end;
  logic             rsp_free;

  ipg_parts_ram #(
    .DEPTH (MAX_N),
    .AW    (IW),
    .DW    (VAL_W)
  ) u_parts (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  // clamp n into 1..MAX_N
  always_comb begin
    if (req.n == '0) begin
      n_eff = N_W'(1);
    end else if ((N_W + 1)'(req.n) > (N_W + 1)'(MAX_N)) begin
      n_eff = N_W'(MAX_N);
    end else begin
      n_eff = req.n;
    end
  end

  assign head = IW'(hp1 - HW'(1));

  // parts past the head index are ones by construction
  assign part    = (HW'(idx) >= hp1) ? VAL_W'(1) : mem_rdata;
  assign sum_new = sum + SW'(part);
  assign run_end = (sum_new >= SW'(target)) || (idx == IW'(MAX_N - 1));

  always_comb begin
    state_next     = state;
    hp1_next       = hp1;
    tail_next      = tail;
    target_next    = target;
    counter_next   = counter;
    active_next    = active;
    p0_one_next    = p0_one;
    r_next         = r;
    t_next         = t;
    idx_next       = idx;
    sum_next       = sum;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = idx;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.op == OP_START) begin
            // first partition is [n]; everything past index zero reads as one
            mem_we       = 1'b1;
            mem_waddr    = '0;
            mem_wdata    = VAL_W'(n_eff);
            hp1_next     = HW'(1);
            tail_next    = '0;
            target_next  = n_eff;
            counter_next = '0;
            active_next  = 1'b1;
            p0_one_next  = (n_eff == N_W'(1));
            mem_raddr    = '0;
            idx_next     = '0;
            sum_next     = '0;
            state_next   = ST_EMIT;
          end else if (!active || p0_one) begin
            state_next = ST_EXH;
          end else begin
            // fetch the head part
            mem_raddr  = head;
            state_next = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (mem_rdata < VAL_W'(2)) begin
          state_next = ST_EXH;
        end else if (mem_rdata == VAL_W'(2)) begin
          // head of two becomes one and one, tail grows by one
          mem_we       = 1'b1;
          mem_waddr    = head;
          mem_wdata    = VAL_W'(1);
          if (head == '0) begin
            p0_one_next = 1'b1;
          end
          hp1_next     = hp1 - HW'(1);
          tail_next    = tail + IW'(1);
          counter_next = counter + NUM_W'(1);
          mem_raddr    = '0;
          idx_next     = '0;
          sum_next     = '0;
          state_next   = ST_EMIT;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = head;
          mem_wdata  = mem_rdata - VAL_W'(1);
          r_next     = mem_rdata - VAL_W'(1);
          t_next     = TW'(tail) + TW'(2) - TW'(hp1);
          state_next = ST_SPLIT;
        end
      end

      ST_SPLIT: begin
        if (t >= TW'(r)) begin
          // one more copy of the reduced part
          mem_we    = 1'b1;
          mem_waddr = IW'(hp1);
          mem_wdata = r;
          hp1_next  = hp1 + HW'(1);
          t_next    = t - TW'(r);
        end else begin
          if (t == '0) begin
            tail_next = IW'(hp1 - HW'(1));
          end else begin
            tail_next = IW'(hp1);
            if (t > TW'(1)) begin
              mem_we    = 1'b1;
              mem_waddr = IW'(hp1);
              mem_wdata = VAL_W'(t);
              hp1_next  = hp1 + HW'(1);
            end
          end
          counter_next = counter + NUM_W'(1);
          mem_raddr    = '0;
          idx_next     = '0;
          sum_next     = '0;
          state_next   = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (rsp_free) begin
          rsp_valid_next            = 1'b1;
          rsp_next.part_value       = part;
          rsp_next.part_position    = POS_W'(idx);
          rsp_next.last_part        = run_end;
          rsp_next.final_partition  = p0_one;
          rsp_next.exhausted        = 1'b0;
          rsp_next.partition_number = counter;
          sum_next                  = sum_new;
          if (run_end) begin
            state_next = ST_IDLE;
          end else begin
            idx_next  = idx + IW'(1);
            mem_raddr = idx + IW'(1);
          end
        end
      end

      ST_EXH: begin
        if (rsp_free) begin
          rsp_valid_next            = 1'b1;
          rsp_next.part_value       = '0;
          rsp_next.part_position    = '0;
          rsp_next.last_part        = 1'b1;
          rsp_next.final_partition  = 1'b0;
          rsp_next.exhausted        = 1'b1;
          rsp_next.partition_number = counter;
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hp1       <= '0;
      tail      <= '0;
      target    <= N_W'(1);
      counter   <= '0;
      active    <= 1'b0;
      p0_one    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hp1       <= hp1_next;
      tail      <= tail_next;
      target    <= target_next;
      counter   <= counter_next;
      active    <= active_next;
      p0_one    <= p0_one_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    r   <= r_next;
    t   <= t_next;
    idx <= idx_next;
    sum <= sum_next;
    rsp <= rsp_next;
  end

endmodule

FILE: sv/ipg_checker.sv
// ipg_checker: port-level checks for the integer partition generator
// depends on ipg_pkg; bound to integer_partition_generator below
module ipg_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ipg_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ipg_pkg::rsp_t rsp
);

  import ipg_pkg::*;

  // waiting request word holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request word changed or dropped while waiting");

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed or dropped while stalled");

  // one request in flight at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in work");

  // refused advance is a single empty word
  a_exh_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.exhausted |->
      rsp.last_part && (rsp.part_value == '0) && (rsp.part_position == '0)
      && !rsp.final_partition)
    else $error("malformed exhausted word");

  // all-ones partition carries only ones, real parts are never zero
  a_part_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.exhausted |->
      (rsp.part_value != '0) && (!rsp.final_partition || (rsp.part_value == VAL_W'(1))))
    else $error("bad part value");

endmodule

bind integer_partition_generator ipg_checker u_ipg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
